>>> rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and codes for the ring deque with cancel.
// ----------------------------------------------------------------------------
package rdq_pkg;

  // The ring never has fewer slots than this.
  localparam int MIN_SLOTS = 16;

  localparam int FUNC_W   = 3;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [ID_W-1:0]     id_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FN_PUSH_BACK  = 3'd0;
  localparam func_t FN_PUSH_FRONT = 3'd1;
  localparam func_t FN_POP        = 3'd2;
  localparam func_t FN_CONTAINS   = 3'd3;
  localparam func_t FN_CANCEL     = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_BADID = 2'd3;

endpackage

>>> rtl/rdq_ram.sv
// ----------------------------------------------------------------------------
// rdq_ram
// Slot store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdq_ram #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ring_deque_with_cancel_core.sv
// ----------------------------------------------------------------------------
// ring_deque_with_cancel_core
// Circular deque of task identifiers with push back, push front, pop,
// contains and cancel, sequenced over a single-port-pair slot memory.
// ----------------------------------------------------------------------------
//  Channel | Ports                                     | Transaction
//  --------+-------------------------------------------+-----------------------
//  input   | start, busy, in_func, in_entry_id         | start high, busy low
//  result  | out_valid, out_id, out_found, out_status  | out_valid, one cycle
//
//  Push, rejected ids, pop on empty and unused codes: result in the cycle
//  after the transaction. Pop: the front slot is read from the memory, then
//  handed out from the pop state. Contains scans the live slots from the front,
//  cancel every slot from slot 0, one slot compare a cycle through the memory read port.
//  After reset the block clears every slot of the store with busy high.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module ring_deque_with_cancel_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rdq_pkg::func_t   in_func,
  input  rdq_pkg::id_t     in_entry_id,
  output logic             out_valid,
  output rdq_pkg::id_t     out_id,
  output logic             out_found,
  output rdq_pkg::status_t out_status
);

  import rdq_pkg::*;

  localparam int RING = (QUEUE_DEPTH <= MIN_SLOTS) ? MIN_SLOTS
                                                   : (1 << $clog2(QUEUE_DEPTH));
  localparam int PW   = $clog2(RING);
  localparam int SW   = (ID_WIDTH < ID_W) ? ID_WIDTH : ID_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_POP   = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] front_r, front_nxt;
  logic [PW-1:0] back_r, back_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] scan_r, scan_nxt;
  logic [PW-1:0] left_r, left_nxt;
  logic [SW-1:0] key_r, key_nxt;
  logic          cancel_r, cancel_nxt;

  logic          out_valid_r, out_valid_nxt;
  id_t           out_id_r, out_id_nxt;
  logic          out_found_r, out_found_nxt;
  status_t       out_status_r, out_status_nxt;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  logic [SW-1:0] mem_rdata;

  logic [SW-1:0] in_key;
  logic          key_zero;
  logic          empty;
  logic          full;
  logic          hit;

  rdq_ram #(
    .DEPTH  (RING),
    .DATA_W (SW),
    .ADDR_W (PW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_key   = in_entry_id[SW-1:0];
  assign key_zero = (in_key == '0);
  assign empty    = (front_r == back_r);
  assign full     = ((back_r + PW'(1)) == front_r);
  assign hit      = (mem_rdata == key_r);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    clr_nxt        = clr_r;
    scan_nxt       = scan_r;
    left_nxt       = left_r;
    key_nxt        = key_r;
    cancel_nxt     = cancel_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = '0;
    out_found_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + PW'(1);
        if (clr_r == PW'(RING - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          key_nxt = in_key;
          unique case (in_func)
            FN_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (key_zero) begin
                out_status_nxt = ST_BADID;
              end else if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = back_r;
                mem_wdata = in_key;
                back_nxt  = back_r + PW'(1);
              end
            end
            FN_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (key_zero) begin
                out_status_nxt = ST_BADID;
              end else if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_r - PW'(1);
                mem_wdata = in_key;
                front_nxt = front_r - PW'(1);
              end
            end
            FN_POP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_r;
                state_nxt = S_POP;
              end
            end
            FN_CONTAINS: begin
              if (key_zero) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BADID;
              end else if (empty) begin
                out_valid_nxt = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = front_r;
                scan_nxt   = front_r;
                left_nxt   = back_r - front_r - PW'(1);
                cancel_nxt = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            FN_CANCEL: begin
              if (key_zero) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BADID;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                scan_nxt   = '0;
                left_nxt   = PW'(RING - 1);
                cancel_nxt = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_POP: begin
        // Read data of the front slot is here; hand it out and clear the slot.
        out_valid_nxt = 1'b1;
        out_id_nxt    = ID_W'(mem_rdata);
        mem_we        = 1'b1;
        mem_waddr     = front_r;
        front_nxt     = front_r + PW'(1);
        state_nxt     = S_IDLE;
      end

      S_SCAN: begin
        // Read data belongs to scan_r; the next read is issued in the same cycle.
        if (hit) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          if (cancel_r) begin
            mem_we    = 1'b1;
            mem_waddr = scan_r;
          end
          state_nxt = S_IDLE;
        end else if (left_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_r + PW'(1);
          scan_nxt  = scan_r + PW'(1);
          left_nxt  = left_r - PW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      front_r     <= '0;
      back_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    left_r       <= left_nxt;
    key_r        <= key_nxt;
    cancel_r     <= cancel_nxt;
    out_id_r     <= out_id_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

endmodule

>>> rtl/rdq_checker.sv
// ----------------------------------------------------------------------------
// rdq_port_checker
// Port-level checks for the ring deque core, bound to the top level.
// ----------------------------------------------------------------------------
module rdq_port_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input rdq_pkg::func_t   in_func,
  input logic             out_valid,
  input rdq_pkg::id_t     out_id,
  input logic             out_found,
  input rdq_pkg::status_t out_status
);

  import rdq_pkg::*;

  // The store is cleared after reset, so the block must come up busy.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // A push transaction always answers in the next cycle.
  a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FN_PUSH_BACK || in_func == FN_PUSH_FRONT))
    |=> out_valid)
    else $error("push result missing one cycle after the transaction");

  // A match is only reported with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_OK && out_id == '0))
    else $error("found set with a nonzero status or id");

  // Only a successful pop returns an identifier.
  a_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_id != '0) |-> (out_status == ST_OK && !out_found))
    else $error("identifier returned with an error status");

endmodule

bind ring_deque_with_cancel_core rdq_port_checker u_rdq_checker (.*);
